>>> rtl/core/bse_pkg.sv
`default_nettype none
package bse_pkg;
    localparam int MaxWindow = 63;
    localparam int WinW = 6;
    localparam int IdxW = 16;
    localparam int MaxIdx = 65535;
    localparam int VSumW = 38;
    localparam int SqW = 62;
    localparam int CntW = 7;

    typedef struct packed {
        logic signed [VSumW-1:0] vsum;
        logic [SqW-1:0]          sqsum;
        logic [CntW-1:0]         cnt;
        logic                    last;
        logic                    err;
    } bse_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_DIVV,
        ST_DIVE,
        ST_OUT
    } bse_state_t;

    typedef enum logic [1:0] {
        F_IN,
        F_MAIN,
        F_TAIL
    } bse_fphase_t;
endpackage
`default_nettype wire

>>> rtl/core/bse_sample_if.sv
`default_nettype none
interface bse_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_value;
    logic [27:0]        sample_error;
    logic               value_is_nan;
    logic               last_sample;
    modport source (output valid, sample_value, sample_error, value_is_nan, last_sample,
                    input ready);
    modport sink (input valid, sample_value, sample_error, value_is_nan, last_sample,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/core/bse_result_if.sv
`default_nettype none
interface bse_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] smoothed_value;
    logic [27:0]        smoothed_error;
    logic               last_result;
    logic               too_short;
    modport source (output valid, smoothed_value, smoothed_error, last_result, too_short,
                    input ready);
    modport sink (input valid, smoothed_value, smoothed_error, last_result, too_short,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/core/bse_cfg_if.sv
`default_nettype none
interface bse_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/bse_front.sv
`default_nettype none
module bse_front
    import bse_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    bse_sample_if.sink    smp,
    bse_cfg_if.sink       cfg,
    output bse_job_t      job,
    output logic          job_valid,
    input  wire logic     job_ready
);
    logic [WinW-1:0]          win_reg;
    logic signed [VSumW-1:0]  vsum_reg, vsum_next;
    logic [SqW-1:0]           sq_reg, sq_next;
    logic [IdxW-1:0]          idx_reg;
    logic [WinW-1:0]          ptr_reg;
    bse_fphase_t              ph_reg, ph_next;
    logic [WinW-1:0]          tcnt_reg;
    logic [WinW-1:0]          rdp_reg;
    logic signed [31:0]       vmem [MaxWindow];
    logic [27:0]              emem [MaxWindow];
    logic signed [31:0]       vrd_reg;
    logic [27:0]              erd_reg;
    logic signed [31:0]       in_v_reg;
    logic [27:0]              in_e_reg;
    logic                     in_last_reg;
    logic [WinW-1:0]          w, h;
    logic [WinW-1:0]          ptr_inc, rdp_inc;
    logic                     full;
    logic [CntW-1:0]          cnt;
    logic [55:0]              esq_new, esq_old;
    logic                     rd_ok_reg;

    function automatic logic [WinW-1:0] cfg_fix(input logic [WinW-1:0] r);
        logic [WinW-1:0] t;
        begin
            t = (r < 6'd3) ? 6'd3 : r;
            t = t | 6'd1;
            return t;
        end
    endfunction

    always_comb
    begin
        w = cfg_fix(win_reg);
        h = (w - 6'd1) >> 1;
    end

    assign full    = idx_reg >= IdxW'(w);
    assign ptr_inc = (ptr_reg + 6'd1 == w) ? '0 : ptr_reg + 6'd1;
    assign rdp_inc = (rdp_reg + 6'd1 == w) ? '0 : rdp_reg + 6'd1;
    assign cnt     = full ? CntW'(w) : CntW'(idx_reg + 16'd1);
    assign esq_new = in_e_reg * in_e_reg;
    assign esq_old = erd_reg * erd_reg;

    assign smp.ready = (ph_reg == F_IN) && !rd_ok_reg;
    assign cfg.ready = 1'b1;

    // Read the slot being overwritten into a register ahead of use.
    always_ff @(posedge clk)
    begin
        vrd_reg <= vmem[(ph_reg == F_TAIL) ? rdp_reg : ptr_reg];
        erd_reg <= emem[(ph_reg == F_TAIL) ? rdp_reg : ptr_reg];
        if (smp.valid && smp.ready)
        begin
            in_v_reg    <= smp.value_is_nan ? 32'sd0 : smp.sample_value;
            in_e_reg    <= smp.sample_error;
            in_last_reg <= smp.last_sample;
        end
        if (ph_reg == F_MAIN && (!job_valid || job_ready))
        begin
            vmem[ptr_reg] <= in_v_reg;
            emem[ptr_reg] <= in_e_reg;
        end
    end

    always_comb
    begin
        ph_next = ph_reg;
        case (ph_reg)
            F_IN:
                if (rd_ok_reg)
                    ph_next = F_MAIN;
            F_MAIN:
                if (!job_valid || job_ready)
                    ph_next = (in_last_reg && full) ? F_TAIL : F_IN;
            F_TAIL:
                if (rd_ok_reg && job_ready && job.last)
                    ph_next = F_IN;
            default: ph_next = F_IN;
        endcase
    end

    always_comb
    begin
        vsum_next = vsum_reg + VSumW'(in_v_reg)
                    - (full ? VSumW'(vrd_reg) : '0);
        sq_next = sq_reg + SqW'(esq_new) - (full ? SqW'(esq_old) : '0);
        job = '0;
        job_valid = 1'b0;
        if (ph_reg == F_MAIN)
        begin
            job.vsum = vsum_next;
            job.sqsum = sq_next;
            job.cnt = cnt;
            if (in_last_reg && !full)
            begin
                job.err = 1'b1;
                job.last = 1'b1;
                job.vsum = '0;
                job.sqsum = '0;
                job.cnt = CntW'(1);
                job_valid = 1'b1;
            end
            else
            begin
                job.last = 1'b0;
                job_valid = idx_reg >= IdxW'(h);
            end
        end
        else if (ph_reg == F_TAIL)
        begin
            job.vsum = vsum_reg - VSumW'(vrd_reg);
            job.sqsum = sq_reg - SqW'(esq_old);
            job.cnt = CntW'(w - 6'd1 - tcnt_reg);
            job.last = (tcnt_reg + 6'd1 == h);
            job_valid = rd_ok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= 6'd3;
            vsum_reg <= '0;
            sq_reg <= '0;
            idx_reg <= '0;
            ptr_reg <= '0;
            ph_reg <= F_IN;
            tcnt_reg <= '0;
            rdp_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            win_reg <= cfg.data;
            vsum_reg <= '0;
            sq_reg <= '0;
            idx_reg <= '0;
            ptr_reg <= '0;
            ph_reg <= F_IN;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            ph_reg <= ph_next;
            case (ph_reg)
                F_IN:
                begin
                    // hold off F_MAIN until rd_ok_reg is set so the old slot read settles
                    if (rd_ok_reg)
                        rd_ok_reg <= 1'b0;
                    else if (smp.valid)
                        rd_ok_reg <= 1'b1;
                end
                F_MAIN:
                begin
                    if (!job_valid || job_ready)
                    begin
                        if (in_last_reg)
                        begin
                            if (!full)
                            begin
                                vsum_reg <= '0;
                                sq_reg <= '0;
                                idx_reg <= '0;
                                ptr_reg <= '0;
                            end
                            else
                            begin
                                vsum_reg <= vsum_next;
                                sq_reg <= sq_next;
                                rdp_reg <= ptr_inc;
                                tcnt_reg <= '0;
                            end
                        end
                        else
                        begin
                            vsum_reg <= vsum_next;
                            sq_reg <= sq_next;
                            ptr_reg <= ptr_inc;
                            if (idx_reg != IdxW'(MaxIdx))
                                idx_reg <= idx_reg + 16'd1;
                        end
                    end
                end
                F_TAIL:
                begin
                    if (!rd_ok_reg)
                        rd_ok_reg <= 1'b1;
                    else if (job_ready)
                    begin
                        rd_ok_reg <= 1'b0;
                        vsum_reg <= job.vsum;
                        sq_reg <= job.sqsum;
                        rdp_reg <= rdp_inc;
                        tcnt_reg <= tcnt_reg + 6'd1;
                        if (job.last)
                        begin
                            vsum_reg <= '0;
                            sq_reg <= '0;
                            idx_reg <= '0;
                            ptr_reg <= '0;
                        end
                    end
                end
                default: rd_ok_reg <= 1'b0;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/bse_queue.sv
`default_nettype none
module bse_queue
    import bse_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire bse_job_t in_job,
    input  wire logic     in_valid,
    output logic          in_ready,
    output bse_job_t      out_job,
    output logic          out_valid,
    input  wire logic     out_ready
);
    bse_job_t    q_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  n_reg;

    assign in_ready  = n_reg != 2'd2;
    assign out_valid = n_reg != 2'd0;
    assign out_job   = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            q_reg[wp_reg] <= in_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            n_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                wp_reg <= ~wp_reg;
            if (out_valid && out_ready)
                rp_reg <= ~rp_reg;
            n_reg <= n_reg + 2'((in_valid && in_ready) ? 1 : 0)
                           - 2'((out_valid && out_ready) ? 1 : 0);
        end
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) n_reg <= 2'd2)
        else $error("queue overfill");
endmodule
`default_nettype wire

>>> rtl/core/bse_back.sv
`default_nettype none
module bse_back
    import bse_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire bse_job_t job,
    input  wire logic     job_valid,
    output logic          job_ready,
    bse_result_if.source  res
);
    bse_state_t st_reg, st_next;
    bse_job_t   j_reg;
    logic [SqW-1:0]  x_reg;
    logic [31:0]     r_reg;
    logic [5:0]      k_reg;
    logic [37:0]     rem_reg;
    logic [37:0]     quo_reg;
    logic [37:0]     num_reg;
    logic            neg_reg;
    logic [31:0]     qv_reg;
    logic [63:0]     trial;
    logic [33:0]     sub;
    logic [38:0]     rem_sh;
    logic [37:0]     mag;
    logic            q_bit;

    assign job_ready = st_reg == ST_IDLE;
    assign mag = j_reg.vsum[VSumW-1] ? 38'(-j_reg.vsum) : 38'(j_reg.vsum);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (job_valid) st_next = ST_SQRT;
            ST_SQRT: if (k_reg == 6'd0) st_next = ST_DIVV;
            ST_DIVV: if (k_reg == 6'd0) st_next = ST_DIVE;
            ST_DIVE: if (k_reg == 6'd0) st_next = ST_OUT;
            ST_OUT:  if (res.ready) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        res.valid = st_reg == ST_OUT;
        res.smoothed_value = j_reg.err ? 32'sd0 : qv_reg;
        res.smoothed_error = j_reg.err ? 28'd0 : quo_reg[27:0];
        res.last_result = j_reg.last;
        res.too_short = j_reg.err;
    end

    // one root bit per cycle, restoring
    assign trial  = 64'({rem_reg[31:0], x_reg[SqW-1 -: 2]});
    assign sub    = 34'(trial) - {r_reg, 2'b01};
    assign rem_sh = {rem_reg, num_reg[37]};
    assign q_bit  = rem_sh >= 39'(j_reg.cnt);

    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_IDLE:
            begin
                j_reg <= job;
                x_reg <= job.sqsum;
                r_reg <= '0;
                rem_reg <= '0;
                k_reg <= 6'd30;
            end
            ST_SQRT:
            begin
                x_reg <= {x_reg[SqW-3:0], 2'b00};
                if (!sub[33])
                begin
                    rem_reg <= 38'(sub);
                    r_reg <= {r_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= 38'(trial);
                    r_reg <= {r_reg[30:0], 1'b0};
                end
                if (k_reg == 6'd0)
                begin
                    num_reg <= mag + 38'(j_reg.cnt >> 1);
                    neg_reg <= j_reg.vsum[VSumW-1];
                    rem_reg <= '0;
                    k_reg <= 6'd37;
                end
                else
                    k_reg <= k_reg - 6'd1;
            end
            ST_DIVV, ST_DIVE:
            begin
                num_reg <= {num_reg[36:0], 1'b0};
                if (q_bit)
                begin
                    rem_reg <= 38'(rem_sh - 39'(j_reg.cnt));
                    quo_reg <= {quo_reg[36:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[37:0];
                    quo_reg <= {quo_reg[36:0], 1'b0};
                end
                if (k_reg == 6'd0)
                begin
                    if (st_reg == ST_DIVV)
                    begin
                        qv_reg <= neg_reg ? -{quo_reg[30:0], q_bit} :
                                            {quo_reg[30:0], q_bit};
                        num_reg <= 38'(r_reg) + 38'(j_reg.cnt >> 1);
                        rem_reg <= '0;
                        k_reg <= 6'd37;
                    end
                end
                else
                    k_reg <= k_reg - 6'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_IDLE;
        else
            st_reg <= st_next;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_OUT && !res.ready |=> st_reg == ST_OUT)
        else $error("result dropped");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job_ready |=> st_reg == ST_SQRT)
        else $error("job not started");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_OUT |-> j_reg.cnt != '0)
        else $error("zero count");
endmodule
`default_nettype wire

>>> rtl/core/boxcar_smoother_with_error.sv
`default_nettype none
// channel  | dir | payload
// smp      | in  | sample_value, sample_error, value_is_nan, last_sample
// res      | out | smoothed_value, smoothed_error, last_result, too_short
// cfg      | in  | data = window_points
// Back end per result: a load in ST_IDLE, a 31-step root, two 38-step dividers
// and ST_OUT. The front end waits on an old slot read per word and per tail result,
// and runs ahead through a two-entry queue.
// A full queue holds the front end; a low res.ready holds the back end on its word.
// rst_n clears sums, index, pointer and window (3); delay lines are not cleared.
module boxcar_smoother_with_error
    import bse_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bse_sample_if.sink smp,
    bse_cfg_if.sink    cfg,
    bse_result_if.source res
);
    bse_job_t f_job, b_job;
    logic     f_valid, f_ready, b_valid, b_ready;

    bse_front u_front (.clk, .rst_n, .smp, .cfg, .job(f_job), .job_valid(f_valid),
                       .job_ready(f_ready));
    bse_queue u_queue (.clk, .rst_n, .in_job(f_job), .in_valid(f_valid),
                       .in_ready(f_ready), .out_job(b_job), .out_valid(b_valid),
                       .out_ready(b_ready));
    bse_back u_back (.clk, .rst_n, .job(b_job), .job_valid(b_valid),
                     .job_ready(b_ready), .res);
endmodule
`default_nettype wire
